@@ rtl/trd_pkg.sv @@
// Shared types and constants for the run-length image pixel decoder.
`default_nettype none
package trd_pkg;

	// Packet header bytes at or above this value open a run packet.
	localparam int unsigned MaxPacket = 128;

	// Configuration register indexes.
	localparam logic CFG_BYTES_PER_PIXEL = 1'b0;
	localparam logic CFG_PIXEL_COUNT     = 1'b1;

	// Reset values of the configuration registers.
	localparam logic [2:0]  BPP_RESET        = 3'd3;
	localparam logic [31:0] PIXEL_COUNT_RESET = 32'd1;

	// One decoded pixel word as it passes from the parser to the output stage.
	typedef struct packed {
		logic [23:0] assembly;
		logic [7:0]  final_byte;
		logic [1:0]  final_pos;
		logic [7:0]  repeat_count;
		logic        last_of_image;
		logic        status;
	} trd_item_t;

endpackage
`default_nettype wire

@@ rtl/tga_rle_pixel_decoder.sv @@
// Top level of the run-length image pixel decoder.
//
// The input channel takes one byte of run-length image data per word
// (in_valid, in_stall, byte_in). Header bytes and all but the last byte of
// each pixel produce nothing. The last byte of a pixel produces one output
// word: the pixel, its repeat count, and the last_of_image and status flags.
// The consumer expands the repeats itself.
// A byte is taken every cycle while in_stall is low. The word for a
// completed pixel is written into the queue at the edge that takes its
// last byte, and from there passes through the output register.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is
// always ready; index 0 holds bytes per pixel, index 1 the image pixel count.
// When the receiver stalls, the output word holds and a two-word queue fills;
// once it is full, in_stall rises until the receiver takes a word.
// Reset clears the parser to await a packet header at the start of an image,
// empties the queue and output, and sets bytes per pixel to 3 and the pixel
// count to 1.
`default_nettype none
module tga_rle_pixel_decoder (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [7:0]  byte_in,
	output logic        out_valid,
	input  wire         out_stall,
	output logic [31:0] pixel_value,
	output logic [7:0]  repeat_count,
	output logic        last_of_image,
	output logic        status,
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire         cfg_index,
	input  wire  [31:0] cfg_data
);

	trd_pkg::trd_item_t push_item;
	trd_pkg::trd_item_t head;
	logic q_push;
	logic q_full;
	logic q_pop;
	logic q_nonempty;

	assign cfg_ready = 1'b1;

	trd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.byte_in   (byte_in),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_item    (push_item)
	);

	trd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.nonempty  (q_nonempty),
		.head      (head)
	);

	trd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_nonempty    (q_nonempty),
		.q_head        (head),
		.q_pop         (q_pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.pixel_value   (pixel_value),
		.repeat_count  (repeat_count),
		.last_of_image (last_of_image),
		.status        (status)
	);

endmodule
`default_nettype wire

@@ rtl/trd_front.sv @@
// Packet parser: header decode, pixel byte gathering and image pixel accounting.
`default_nettype none
module trd_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_stall,
	input  wire  [7:0]          byte_in,
	input  wire                 cfg_valid,
	input  wire                 cfg_index,
	input  wire  [31:0]         cfg_data,
	input  wire                 q_full,
	output logic                q_push,
	output trd_pkg::trd_item_t  q_item
);

	logic [2:0]  bpp_q;
	logic [31:0] pixel_count_q;
	logic        expect_header_q;
	logic        run_packet_q;
	logic [7:0]  left_q;
	logic [1:0]  pos_q;
	logic [23:0] asm_q;
	logic [31:0] done_q;

	logic        accept;
	logic [2:0]  eff_bpp;
	logic        need_more;
	logic [7:0]  repeat_raw;
	logic [7:0]  repeat_val;
	logic [32:0] diff;
	logic [31:0] remaining;
	logic        overflow;
	logic        image_done;
	logic [7:0]  left_next;
	logic        packet_end;
	logic        finish_pixel;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	// Configuration registers; a write goes through at once.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpp_q         <= trd_pkg::BPP_RESET;
			pixel_count_q <= trd_pkg::PIXEL_COUNT_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				trd_pkg::CFG_BYTES_PER_PIXEL: bpp_q <= cfg_data[2:0];
				trd_pkg::CFG_PIXEL_COUNT:     pixel_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Classify the byte and work out the pixel bookkeeping.
	always_comb begin
		if (bpp_q == 3'd0) begin
			eff_bpp = 3'd1;
		end else if (bpp_q > 3'd4) begin
			eff_bpp = 3'd4;
		end else begin
			eff_bpp = bpp_q;
		end
		need_more  = ({1'b0, pos_q} + 3'd1) < eff_bpp;
		repeat_raw = run_packet_q ? left_q : 8'd1;
		repeat_val = (repeat_raw == 8'd0) ? 8'd1 : repeat_raw;
		diff       = {1'b0, pixel_count_q} - {1'b0, done_q};
		remaining  = diff[32] ? 32'd0 : diff[31:0];
		overflow   = (remaining[31:8] == 24'd0) && (repeat_val > remaining[7:0]);
		// The image ends exactly when this repeat uses up what remains.
		image_done = !overflow && (remaining == {24'd0, repeat_val});
		left_next  = (left_q >= repeat_val) ? (left_q - repeat_val) : 8'd0;
		packet_end = (left_next == 8'd0);
		finish_pixel = accept && !expect_header_q && !need_more;
	end

	// Result word handed to the queue.
	always_comb begin
		q_push              = finish_pixel;
		q_item.assembly     = asm_q;
		q_item.final_byte   = byte_in;
		q_item.final_pos    = pos_q;
		q_item.repeat_count = overflow ? remaining[7:0] : repeat_val;
		q_item.last_of_image = overflow || (packet_end && image_done);
		q_item.status       = overflow;
	end

	// Parser state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_header_q <= 1'b1;
			run_packet_q    <= 1'b0;
			left_q          <= 8'd0;
			pos_q           <= 2'd0;
			asm_q           <= 24'd0;
			done_q          <= 32'd0;
		end else if (accept) begin
			if (expect_header_q) begin
				// Both packet kinds carry their length as the low seven bits plus one.
				run_packet_q    <= byte_in[7];
				left_q          <= {1'b0, byte_in[6:0]} + 8'd1;
				expect_header_q <= 1'b0;
				pos_q           <= 2'd0;
				asm_q           <= 24'd0;
			end else if (need_more) begin
				unique case (pos_q)
					2'd0:    asm_q[7:0]   <= asm_q[7:0] | byte_in;
					2'd1:    asm_q[15:8]  <= asm_q[15:8] | byte_in;
					2'd2:    asm_q[23:16] <= asm_q[23:16] | byte_in;
					default: ;
				endcase
				pos_q <= pos_q + 2'd1;
			end else begin
				pos_q <= 2'd0;
				asm_q <= 24'd0;
				if (overflow || (packet_end && image_done)) begin
					// Rearm for the next image.
					expect_header_q <= 1'b1;
					run_packet_q    <= 1'b0;
					left_q          <= 8'd0;
					done_q          <= 32'd0;
				end else begin
					done_q <= done_q + {24'd0, repeat_val};
					left_q <= left_next;
					if (packet_end) begin
						expect_header_q <= 1'b1;
					end
				end
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/trd_queue.sv @@
// Two-entry queue between the parser and the output stage.
`default_nettype none
module trd_queue (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	input  trd_pkg::trd_item_t  push_item,
	output logic                full,
	input  wire                 pop,
	output logic                nonempty,
	output trd_pkg::trd_item_t  head
);

	trd_pkg::trd_item_t mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full     = (count_q == 2'd2);
	assign nonempty = (count_q != 2'd0);
	assign head     = mem_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

@@ rtl/trd_back.sv @@
// Output stage: finishes the pixel word and holds it for the receiver.
`default_nettype none
module trd_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 q_nonempty,
	input  trd_pkg::trd_item_t  q_head,
	output logic                q_pop,
	output logic                out_valid,
	input  wire                 out_stall,
	output logic [31:0]         pixel_value,
	output logic [7:0]          repeat_count,
	output logic                last_of_image,
	output logic                status
);

	logic        valid_q;
	logic [31:0] pixel_q;
	logic [7:0]  repeat_q;
	logic        last_q;
	logic        status_q;
	logic [31:0] pixel_full;

	assign q_pop = q_nonempty && (!valid_q || !out_stall);

	// Merge the last byte into the gathered bytes at its position.
	assign pixel_full = {8'd0, q_head.assembly}
		| ({24'd0, q_head.final_byte} << {q_head.final_pos, 3'b000});

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (q_pop) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			pixel_q  <= pixel_full;
			repeat_q <= q_head.repeat_count;
			last_q   <= q_head.last_of_image;
			status_q <= q_head.status;
		end
	end

	assign out_valid     = valid_q;
	assign pixel_value   = pixel_q;
	assign repeat_count  = repeat_q;
	assign last_of_image = last_q;
	assign status        = status_q;

endmodule
`default_nettype wire
